// ===== hdl/bswr_pkg.sv =====
// Shared types and constants for the bounded stack with roll.
// Used by bswr_ctrl, bounded_stack_with_roll_core and bswr_chk.
package bswr_pkg;

    localparam int STACK_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int LVL_W       = 11;
    localparam int WORD_W      = 32;
    localparam int FUNC_W      = 2;
    localparam int STAT_W      = 2;

    localparam int TDATA_IN_W  = ((WORD_W + LVL_W + 7) / 8) * 8;
    localparam int TDATA_OUT_W = ((LVL_W + WORD_W + 7) / 8) * 8;

    localparam logic [LVL_W-1:0]  DEPTH_LVL = LVL_W'(STACK_DEPTH);
    localparam logic [LVL_W-1:0]  CAP_RESET = LVL_W'(STACK_DEPTH);

    localparam logic [FUNC_W-1:0] FN_PUSH = FUNC_W'(0);
    localparam logic [FUNC_W-1:0] FN_POP  = FUNC_W'(1);
    localparam logic [FUNC_W-1:0] FN_ROLL = FUNC_W'(2);

    typedef enum logic [STAT_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_DEEP  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP_RD,
        S_ROLL_HELD,
        S_ROLL_MOV,
        S_ROLL_END
    } t_state;

    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic signed [WORD_W-1:0] push_value;
        logic [LVL_W-1:0]         roll_depth;
    } t_item;

    typedef struct packed {
        t_status                  status;
        logic [LVL_W-1:0]         level;
        logic signed [WORD_W-1:0] top_word;
    } t_result;

endpackage

// ===== hdl/bswr_ram.sv =====
// Simple dual-port synchronous RAM: one write port, one read port,
// registered read data. No dependencies.
module bswr_ram #(
    parameter int DATA_W = 32,
    parameter int ADDR_W = 10
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/bswr_ctrl.sv =====
// Operation sequencer for the stack: fill count, cached top word, roll walk
// over the entry RAM, and the result register. Depends on bswr_pkg.
module bswr_ctrl (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  bswr_pkg::t_item                    i_item,
    output logic                               o_ready,
    input  logic [bswr_pkg::LVL_W-1:0]         i_capacity,
    output logic                               o_out_valid,
    output bswr_pkg::t_result                  o_result,
    input  logic                               i_out_ready,
    output logic                               o_mem_we,
    output logic [bswr_pkg::ADDR_W-1:0]        o_mem_waddr,
    output logic [bswr_pkg::WORD_W-1:0]        o_mem_wdata,
    output logic                               o_mem_re,
    output logic [bswr_pkg::ADDR_W-1:0]        o_mem_raddr,
    input  logic [bswr_pkg::WORD_W-1:0]        i_mem_rdata
);

    bswr_pkg::t_state                 r_state, n_state;
    logic [bswr_pkg::LVL_W-1:0]       r_fill, n_fill;
    logic signed [bswr_pkg::WORD_W-1:0] r_top, n_top;
    logic [bswr_pkg::WORD_W-1:0]      r_held, n_held;
    logic [bswr_pkg::ADDR_W-1:0]      r_k, n_k;
    logic [bswr_pkg::ADDR_W-1:0]      r_end, n_end;
    bswr_pkg::t_status                r_status, n_status;
    logic                             r_ovalid, n_ovalid;

    logic                             accept;
    logic [bswr_pkg::LVL_W-1:0]       eff_cap;
    logic [bswr_pkg::LVL_W-1:0]       roll_base;
    logic [bswr_pkg::LVL_W-1:0]       fill_m1;
    logic [bswr_pkg::LVL_W-1:0]       fill_m2;
    logic [bswr_pkg::ADDR_W-1:0]      k_p1;
    logic                             roll_ok;

    assign o_ready   = (r_state == bswr_pkg::S_IDLE) && (!r_ovalid || i_out_ready);
    assign accept    = i_valid && o_ready;
    assign eff_cap   = (i_capacity > bswr_pkg::DEPTH_LVL) ? bswr_pkg::DEPTH_LVL : i_capacity;
    assign roll_base = r_fill - i_item.roll_depth;
    assign fill_m1   = r_fill - bswr_pkg::LVL_W'(1);
    assign fill_m2   = r_fill - bswr_pkg::LVL_W'(2);
    assign k_p1      = r_k + bswr_pkg::ADDR_W'(1);
    assign roll_ok   = (i_item.roll_depth <= r_fill)
                     && (i_item.roll_depth >= bswr_pkg::LVL_W'(2));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            bswr_pkg::S_IDLE: begin
                if (accept) begin
                    case (i_item.func)
                        bswr_pkg::FN_POP: begin
                            if (r_fill > bswr_pkg::LVL_W'(1)) begin
                                n_state = bswr_pkg::S_POP_RD;
                            end
                        end
                        bswr_pkg::FN_ROLL: begin
                            if (roll_ok) begin
                                n_state = bswr_pkg::S_ROLL_HELD;
                            end
                        end
                        default: n_state = bswr_pkg::S_IDLE;
                    endcase
                end
            end
            bswr_pkg::S_POP_RD:    n_state = bswr_pkg::S_IDLE;
            bswr_pkg::S_ROLL_HELD: n_state = bswr_pkg::S_ROLL_MOV;
            bswr_pkg::S_ROLL_MOV: begin
                if (k_p1 == r_end) begin
                    n_state = bswr_pkg::S_ROLL_END;
                end
            end
            bswr_pkg::S_ROLL_END:  n_state = bswr_pkg::S_IDLE;
            default:               n_state = bswr_pkg::S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_fill      = r_fill;
        n_top       = r_top;
        n_held      = r_held;
        n_k         = r_k;
        n_end       = r_end;
        n_status    = r_status;
        n_ovalid    = r_ovalid && !i_out_ready;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_k;
        o_mem_wdata = i_mem_rdata;
        o_mem_re    = 1'b0;
        o_mem_raddr = k_p1;
        case (r_state)
            bswr_pkg::S_IDLE: begin
                if (accept) begin
                    n_status = bswr_pkg::ST_DONE;
                    n_ovalid = 1'b1;
                    case (i_item.func)
                        bswr_pkg::FN_PUSH: begin
                            if (r_fill >= eff_cap) begin
                                n_status = bswr_pkg::ST_FULL;
                            end else begin
                                o_mem_we    = 1'b1;
                                o_mem_waddr = r_fill[bswr_pkg::ADDR_W-1:0];
                                o_mem_wdata = i_item.push_value;
                                n_top       = i_item.push_value;
                                n_fill      = r_fill + bswr_pkg::LVL_W'(1);
                            end
                        end
                        bswr_pkg::FN_POP: begin
                            if (r_fill == '0) begin
                                n_status = bswr_pkg::ST_EMPTY;
                            end else begin
                                n_fill = fill_m1;
                                if (r_fill == bswr_pkg::LVL_W'(1)) begin
                                    n_top = '0;
                                end else begin
                                    // fetch the new top; result waits for it
                                    o_mem_re    = 1'b1;
                                    o_mem_raddr = fill_m2[bswr_pkg::ADDR_W-1:0];
                                    n_ovalid    = 1'b0;
                                end
                            end
                        end
                        bswr_pkg::FN_ROLL: begin
                            if (i_item.roll_depth > r_fill) begin
                                n_status = bswr_pkg::ST_DEEP;
                            end else if (roll_ok) begin
                                o_mem_re    = 1'b1;
                                o_mem_raddr = roll_base[bswr_pkg::ADDR_W-1:0];
                                n_k         = roll_base[bswr_pkg::ADDR_W-1:0];
                                n_end       = fill_m1[bswr_pkg::ADDR_W-1:0];
                                n_ovalid    = 1'b0;
                            end
                        end
                        default: n_status = bswr_pkg::ST_DONE;
                    endcase
                end
            end
            bswr_pkg::S_POP_RD: begin
                n_top    = i_mem_rdata;
                n_ovalid = 1'b1;
            end
            bswr_pkg::S_ROLL_HELD: begin
                // hold the buried entry, start streaming the ones above it
                n_held      = i_mem_rdata;
                o_mem_re    = 1'b1;
                o_mem_raddr = k_p1;
            end
            bswr_pkg::S_ROLL_MOV: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_k;
                o_mem_wdata = i_mem_rdata;
                if (k_p1 != r_end) begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = k_p1 + bswr_pkg::ADDR_W'(1);
                    n_k         = k_p1;
                end
            end
            bswr_pkg::S_ROLL_END: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_end;
                o_mem_wdata = r_held;
                n_top       = r_held;
                n_ovalid    = 1'b1;
            end
            default: n_ovalid = r_ovalid;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= bswr_pkg::S_IDLE;
            r_fill   <= '0;
            r_top    <= '0;
            r_ovalid <= 1'b0;
            r_status <= bswr_pkg::ST_DONE;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_top    <= n_top;
            r_ovalid <= n_ovalid;
            r_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        r_held <= n_held;
        r_k    <= n_k;
        r_end  <= n_end;
    end

    assign o_out_valid       = r_ovalid;
    assign o_result.status   = r_status;
    assign o_result.level    = r_fill;
    assign o_result.top_word = r_top;

endmodule

// ===== hdl/bounded_stack_with_roll_core.sv =====
// Bounded LIFO stack of signed words with push, pop and roll.
// Depends on bswr_pkg, bswr_ctrl and bswr_ram.
//
// Usage:
//   s_axis carries one operation per beat: tuser holds the operation code
//   (push, pop, roll); tdata holds the push word and the roll depth.
//   m_axis returns one result beat per operation: tuser holds the status,
//   tdata the level after the operation and the top word (0 when empty).
//   i_cfg_we / i_cfg_wdata set the capacity; write only while idle.
// Sequencing (accept to result valid):
//   push, refused push, pop to empty, pop on empty, rejected roll, roll of
//   depth 0 or 1: result valid in the next cycle. Pop leaving entries:
//   RAM read of the new top (S_POP_RD). Roll: S_ROLL_HELD, S_ROLL_MOV with
//   one entry moved per cycle via the single read and write ports of the
//   entry RAM, then S_ROLL_END. One operation is in flight at a time.
// Reset clears the fill count and sets capacity to the full depth; RAM
// contents are left as they are. While m_axis is stalled the result beat
// holds and s_axis_tready stays low, so no operation is lost.
module bounded_stack_with_roll_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [31:0] push_value, [42:32] roll_depth, rest zero
    input  logic [bswr_pkg::TDATA_IN_W-1:0]      s_axis_tdata,
    // [1:0] func
    input  logic [bswr_pkg::FUNC_W-1:0]          s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [10:0] level, [42:11] top_word, rest zero
    output logic [bswr_pkg::TDATA_OUT_W-1:0]     m_axis_tdata,
    // [1:0] status
    output logic [bswr_pkg::STAT_W-1:0]          m_axis_tuser,
    input  logic                                 i_cfg_we,
    input  logic [bswr_pkg::LVL_W-1:0]           i_cfg_wdata
);

    localparam int PAD_OUT = bswr_pkg::TDATA_OUT_W - bswr_pkg::LVL_W - bswr_pkg::WORD_W;

    logic [bswr_pkg::LVL_W-1:0]  r_capacity;
    bswr_pkg::t_item             item;
    bswr_pkg::t_result           result;
    logic                        mem_we;
    logic [bswr_pkg::ADDR_W-1:0] mem_waddr;
    logic [bswr_pkg::WORD_W-1:0] mem_wdata;
    logic                        mem_re;
    logic [bswr_pkg::ADDR_W-1:0] mem_raddr;
    logic [bswr_pkg::WORD_W-1:0] mem_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= bswr_pkg::CAP_RESET;
        end else if (i_cfg_we) begin
            r_capacity <= i_cfg_wdata;
        end
    end

    assign item.func       = s_axis_tuser;
    assign item.push_value = s_axis_tdata[bswr_pkg::WORD_W-1:0];
    assign item.roll_depth = s_axis_tdata[bswr_pkg::WORD_W +: bswr_pkg::LVL_W];

    bswr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .i_item      (item),
        .o_ready     (s_axis_tready),
        .i_capacity  (r_capacity),
        .o_out_valid (m_axis_tvalid),
        .o_result    (result),
        .i_out_ready (m_axis_tready),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    bswr_ram #(
        .DATA_W (bswr_pkg::WORD_W),
        .ADDR_W (bswr_pkg::ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign m_axis_tdata = {{PAD_OUT{1'b0}}, result.top_word, result.level};
    assign m_axis_tuser = result.status;

endmodule

// ===== hdl/bswr_chk.sv =====
// Port-level checks for bounded_stack_with_roll_core, attached by bind.
// Depends on bswr_pkg.
module bswr_chk (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 s_axis_tready,
    input logic                                 m_axis_tvalid,
    input logic                                 m_axis_tready,
    input logic [bswr_pkg::TDATA_OUT_W-1:0]     m_axis_tdata,
    input logic [bswr_pkg::STAT_W-1:0]          m_axis_tuser
);

    logic [bswr_pkg::LVL_W-1:0]  level;
    logic [bswr_pkg::WORD_W-1:0] top_word;

    assign level    = m_axis_tdata[bswr_pkg::LVL_W-1:0];
    assign top_word = m_axis_tdata[bswr_pkg::LVL_W +: bswr_pkg::WORD_W];

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                           && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    a_level_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> level <= bswr_pkg::DEPTH_LVL)
        else $error("level above stack depth");

    a_empty_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && level == '0 |-> top_word == '0)
        else $error("empty stack reports nonzero top word");

    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == bswr_pkg::ST_EMPTY |-> level == '0)
        else $error("pop on empty with nonzero level");

    // no new operation taken while a result waits unread
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("operation accepted while result stalled");

endmodule

bind bounded_stack_with_roll_core bswr_chk u_bswr_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
